// ===== rtl/core/sbda_pkg.sv =====
// Shared constants, a control word type and a helper function for the decimal text converter.
package sbda_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CHAR_W          = 8;
	localparam int BCD_W           = 4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [BCD_W-1:0] BCD_ADJ     = 4'd3;

	// Decimal digits needed for a magnitude of 2**(w-1): floor((w-1)*log10(2)) + 1
	function automatic int num_digits(input int w);
		return (((w - 1) * 1233) >> 12) + 1;
	endfunction

	// Control word driven to every digit cell
	typedef struct packed {
		logic clear;
		logic shift_bit;
		logic shift_digit;
	} cell_ctl_t;

endpackage

// ===== rtl/core/sbda_if.sv =====
// Valid/ready channel interfaces for input integers and output characters.
interface sbda_in_if #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
	logic                          valid;
	logic                          ready;
	logic [sbda_pkg::CHAR_W-1:0]   text_char;
	logic                          last;

	modport source (output valid, output text_char, output last, input ready);
	modport sink   (input valid, input text_char, input last, output ready);
endinterface

// ===== rtl/core/signed_binary_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII text: one transaction in, one character per transaction out.
// An item is accepted, then its magnitude is shifted MSB first, one bit at a time, through the
// row of BCD cells; the sign of a negative value is emitted first, then digits drain from the top
// cell, leading zeros dropped one a cycle. Output stalls hold the emission. A new integer is
// taken only after the last digit has been loaded for output.
// arst_n clears the controller and the digit row; no clearing pass is needed.
module signed_binary_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sbda_in_if.sink     in_ch,
	sbda_out_if.source  out_ch
);
	import sbda_pkg::*;

	localparam int NDIG      = num_digits(VALUE_WIDTH);
	localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W = $clog2(NDIG + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic [DIG_CNT_W-1:0]   rem_q;
	logic                   started_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;

	logic                   in_acc;
	logic                   out_free;
	logic                   skip;
	logic                   sign_go;
	logic                   dig_go;
	logic                   emit_dig;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [BCD_W-1:0]       top_digit;
	cell_ctl_t              ctl;

	logic [BCD_W-1:0] cell_digit [NDIG];
	logic             cell_carry [NDIG];

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign top_digit   = cell_digit[NDIG-1];

	// Form the unsigned magnitude; the most negative value maps onto itself
	assign in_mag = in_ch.value[VALUE_WIDTH-1] ? (~in_ch.value + 1'b1) : in_ch.value;

	// Emission decisions: sign first, then drop leading zeros, then digits
	always_comb begin
		skip     = !started_q && (top_digit == '0) && (rem_q > DIG_CNT_W'(1));
		sign_go  = (state_q == ST_EMIT) && neg_q && out_free;
		emit_dig = (state_q == ST_EMIT) && !neg_q && !skip && out_free;
		dig_go   = (state_q == ST_EMIT) && !neg_q && (skip || out_free);
		ctl.clear       = in_acc;
		ctl.shift_bit   = (state_q == ST_CONV);
		ctl.shift_digit = dig_go;
	end

	// Row of digit cells: bits ripple upward one cell per cycle, digits drain from the top
	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		logic             bit_in;
		logic [BCD_W-1:0] digit_in;
		if (i == 0) begin : g_first
			assign bit_in   = mag_q[VALUE_WIDTH-1];
			assign digit_in = '0;
		end else begin : g_rest
			assign bit_in   = cell_carry[i-1];
			assign digit_in = cell_digit[i-1];
		end
		sbda_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.carry_out (cell_carry[i]),
			.digit     (cell_digit[i])
		);
	end

	// Sequence conversion and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q     <= in_ch.value[VALUE_WIDTH-1];
						bit_cnt_q <= CNT_W'(VALUE_WIDTH);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == CNT_W'(1)) begin
						rem_q     <= DIG_CNT_W'(NDIG);
						started_q <= 1'b0;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sign_go) begin
						neg_q <= 1'b0;
					end else if (dig_go) begin
						rem_q <= rem_q - 1'b1;
						if (!skip) begin
							started_q <= 1'b1;
							if (rem_q == DIG_CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Shift the magnitude out MSB first during conversion
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= in_mag;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	// Output register: drop on transaction, load sign or digit when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sign_go || emit_dig) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sign_go) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (emit_dig) begin
			out_char_q <= CHAR_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
			out_last_q <= (rem_q == DIG_CNT_W'(1));
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.text_char = out_char_q;
	assign out_ch.last      = out_last_q;

endmodule

// ===== rtl/core/sbda_bcd_cell.sv =====
// One BCD digit cell of the double-dabble row: clear, add-3 correction, bit shift, digit shift.
module sbda_bcd_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbda_pkg::cell_ctl_t            ctl,
	input  logic                           bit_in,
	input  logic [sbda_pkg::BCD_W-1:0]     digit_in,
	output logic                           carry_out,
	output logic [sbda_pkg::BCD_W-1:0]     digit
);
	import sbda_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	// Correct digits of five and above before the shift
	always_comb begin
		adj = (digit_q >= BCD_ADJ_MIN) ? digit_q + BCD_ADJ : digit_q;
	end

	assign carry_out = adj[BCD_W-1];
	assign digit     = digit_q;

	// Clear, hold, shift in one bit, or take the neighbor's digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				digit_q <= '0;
			end else if (ctl.shift_bit) begin
				digit_q <= {adj[BCD_W-2:0], bit_in};
			end else if (ctl.shift_digit) begin
				digit_q <= digit_in;
			end else begin
				digit_q <= digit_q;
			end
		end
	end

endmodule

// ===== rtl/core/sbda_checker.sv =====
// Port-level checks on the converter, attached to the top level by bind.
module sbda_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sbda_pkg::CHAR_W-1:0]   text_char,
	input logic                          last
);
	import sbda_pkg::*;

	// Stalled output holds its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(text_char) && $stable(last))
		else $error("output payload changed while stalled");

	// Only a sign or a decimal digit is ever emitted
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == CHAR_MINUS) ||
			((text_char >= CHAR_ZERO) && (text_char <= CHAR_ZERO + 8'd9)))
		else $error("illegal character emitted");

	// A sign is never the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (text_char == CHAR_MINUS) |-> !last)
		else $error("sign marked as last");

	// The block is busy converting right after it takes an integer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after acceptance");

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.text_char (out_ch.text_char),
	.last      (out_ch.last)
);

// ===== verif/sbda_text_checker.sv =====
// Channel monitor and scoreboard for the signed integer to decimal text converter.
module sbda_text_checker #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [VALUE_WIDTH-1:0]       in_value,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [sbda_pkg::CHAR_W-1:0]  out_char,
	input  logic                         out_last,
	output int                           err_count,
	output int                           chars_checked,
	output int                           values_seen,
	output int                           negatives_seen,
	output int                           pending_cnt
);

	typedef struct packed {
		logic [sbda_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} text_char_t;

	// Characters still owed by the block, oldest first
	text_char_t pending_chars[$];
	text_char_t want_char;

	// Append the decimal text of one value to the owed characters
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
		logic                        neg;
		logic [VALUE_WIDTH-1:0]      mag_w;
		logic [63:0]                 mag;
		logic [sbda_pkg::CHAR_W-1:0] digit_buf [0:23];
		int                          nd;
		neg   = v[VALUE_WIDTH-1];
		// unsigned magnitude, so the most negative value stays exact
		mag_w = neg ? (~v + 1'b1) : v;
		mag   = mag_w;
		nd    = 0;
		do begin
			digit_buf[nd] = sbda_pkg::CHAR_ZERO + 8'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0);
		if (neg) begin
			pending_chars.push_back('{sbda_pkg::CHAR_MINUS, 1'b0});
		end
		for (int i = nd - 1; i >= 0; i--) begin
			pending_chars.push_back('{digit_buf[i], (i == 0)});
		end
	endfunction

	// Compare output transactions first, then record the new input transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_chars.delete();
		end else begin
			if (out_valid && out_ready) begin
				chars_checked++;
				if (pending_chars.size() == 0) begin
					err_count++;
					$display("%0t: unexpected character %0d last=%b with nothing owed",
						$time, out_char, out_last);
				end else begin
					want_char = pending_chars.pop_front();
					if (out_char !== want_char.ch || out_last !== want_char.last) begin
						err_count++;
						$display("%0t: mismatch: expected char %0d last=%b, got char %0d last=%b",
							$time, want_char.ch, want_char.last, out_char, out_last);
					end
				end
			end
			if (in_valid && in_ready) begin
				values_seen++;
				if (in_value[VALUE_WIDTH-1]) begin
					negatives_seen++;
				end
				predict_text(in_value);
			end
		end
		pending_cnt = pending_chars.size();
	end

endmodule

// ===== verif/tb_signed_binary_to_decimal_ascii_unit.sv =====
// Testbench top: stimulus, output flow control and verdict for the decimal text converter.
module tb_signed_binary_to_decimal_ascii_unit;

	localparam int VW           = sbda_pkg::VALUE_WIDTH_DEF;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 60;
	localparam int LONG_STALL   = 600;
	localparam int PHASE_ITEMS  = 110;
	localparam int FLOOD_ITEMS  = 40;
	localparam int DRAIN_LIMIT  = 200000;

	logic clk;
	logic arst_n;

	int send_idle;
	int recv_stall;
	int stall_req;
	int stall_ack;

	int check_errs;
	int chars_checked;
	int values_seen;
	int negatives_seen;
	int pending_cnt;

	sbda_in_if #(.VALUE_WIDTH(VW)) in_ch ();
	sbda_out_if                    out_ch ();

	signed_binary_to_decimal_ascii_unit #(
		.VALUE_WIDTH(VW)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sbda_text_checker #(
		.VALUE_WIDTH(VW)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_value       (in_ch.value),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_char       (out_ch.text_char),
		.out_last       (out_ch.last),
		.err_count      (check_errs),
		.chars_checked  (chars_checked),
		.values_seen    (values_seen),
		.negatives_seen (negatives_seen),
		.pending_cnt    (pending_cnt)
	);

	// Free-running clock, period 20
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hard stop for a hung run
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Output flow control: random stalls, or a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		stall_ack    = 0;
		forever begin
			@(negedge clk);
			if (stall_req != stall_ack) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_STALL - 1) @(negedge clk);
				stall_ack = stall_req;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	// Pick a value: full random, short magnitudes, values at and beside powers of ten, extremes
	function automatic logic [VW-1:0] rand_value();
		int              roll;
		int              nd;
		int unsigned     p;
		logic [VW-1:0]   v;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			v = $urandom;
		end else if (roll < 70) begin
			nd = $urandom_range(1, 9);
			p  = 10 ** nd;
			v  = $urandom_range(0, p - 1);
		end else if (roll < 90) begin
			nd = $urandom_range(0, 9);
			p  = 10 ** nd;
			v  = p + $urandom_range(0, 2) - 1;
		end else begin
			case ($urandom_range(0, 3))
				0:       v = '0;
				1:       v = {1'b0, {(VW-1){1'b1}}};
				2:       v = {1'b1, {(VW-1){1'b0}}};
				default: v = {1'b1, {(VW-2){1'b0}}, 1'b1};
			endcase
		end
		if ($urandom_range(0, 1)) begin
			v = -v;
		end
		return v;
	endfunction

	// Offer one value, with random idle cycles first; returns on a falling edge
	task automatic send_value(input logic [VW-1:0] v);
		while ($urandom_range(0, 99) < send_idle) begin
			in_ch.valid <= 1'b0;
			in_ch.value <= $urandom;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold until every owed character has arrived
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_cnt != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	int directed_vals [22] = '{
		0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
		999999999, 1000000000, -999999999, -1000000000,
		2147483647, -2147483647, 32'h8000_0000,
		123456789, -123456789, 1234567890, -1234567890, 7
	};

	int idle_mix [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{29, 29}};

	int guard;

	initial begin
		arst_n      = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		send_idle   = 0;
		recv_stall  = 0;
		stall_req   = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero, extremes, values at and beside powers of ten
		foreach (directed_vals[i]) begin
			send_value(directed_vals[i]);
		end
		drain();

		// random values under each idle mix
		foreach (idle_mix[m]) begin
			send_idle  = idle_mix[m][0];
			recv_stall = idle_mix[m][1];
			repeat (PHASE_ITEMS) send_value(rand_value());
			drain();
		end

		// hold the output off while values keep coming, so the input stalls
		send_idle  = 0;
		recv_stall = 0;
		stall_req++;
		repeat (FLOOD_ITEMS) send_value(rand_value());
		in_ch.valid <= 1'b0;

		// wait out the owed characters, bounded
		guard = 0;
		while (pending_cnt != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		if (pending_cnt != 0) begin
			$display("%0t: %0d characters never arrived", $time, pending_cnt);
			$display("DONE: errors detected");
			$finish;
		end
		repeat (SETTLE) @(negedge clk);

		$display("Converted %0d values (%0d negative), %0d characters checked",
			values_seen, negatives_seen, chars_checked);
		$display("Idle mixes 0/0, 76/0, 0/76, 29/29 plus a %0d-cycle output hold-off",
			LONG_STALL);
		if (check_errs == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sbda_pkg.sv
rtl/core/sbda_if.sv
rtl/core/sbda_bcd_cell.sv
rtl/core/signed_binary_to_decimal_ascii_unit.sv
rtl/core/sbda_checker.sv
verif/sbda_text_checker.sv
verif/tb_signed_binary_to_decimal_ascii_unit.sv
